// ----- src/glu_pkg.sv -----
// ----------------------------------------------------------------------------
// glu_pkg
// Shared widths, command and status types for the GCD/LCM unit.
// ----------------------------------------------------------------------------
package glu_pkg;

  // Widths of the fields on the request and result channels.
  localparam int FIELD_WIDTH = 32;
  localparam int MULT_WIDTH  = 64;

  // Default operand width that the datapath works on.
  localparam int VALUE_WIDTH_DEFAULT = 32;

  // Which division the shared divider runs.
  typedef enum logic {
    DIV_EUCLID = 1'b0,  // remainder of the current Euclid pair
    DIV_QUOT   = 1'b1   // first operand divided by the finished divisor
  } div_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;       // latch a new operand pair
    logic     div_start;  // set up the divider
    div_sel_t div_sel;    // which division to set up
    logic     div_step;   // run one quotient bit
    logic     swap;       // advance the Euclid pair
    logic     mul;        // form the multiple
    logic     publish;    // move the results to the output registers
  } glu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic b_zero;        // second value of the Euclid pair is zero
    logic operand_zero;  // either operand of the request is zero
    logic div_last;      // the divider is on its final bit
  } glu_status_t;

endpackage

// ----- src/glu_in_if.sv -----
// ----------------------------------------------------------------------------
// glu_in_if
// Request channel of the GCD/LCM unit: valid, ready and the operand pair.
// ----------------------------------------------------------------------------
interface glu_in_if;

  logic                            valid;
  logic                            ready;
  logic [glu_pkg::FIELD_WIDTH-1:0] first_value;
  logic [glu_pkg::FIELD_WIDTH-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink (input valid, input first_value, input second_value, output ready);
  modport monitor (input valid, input first_value, input second_value, input ready);

endinterface

// ----- src/glu_out_if.sv -----
// ----------------------------------------------------------------------------
// glu_out_if
// Result channel of the GCD/LCM unit: valid, ready, divisor and multiple.
// ----------------------------------------------------------------------------
interface glu_out_if;

  logic                            valid;
  logic                            ready;
  logic [glu_pkg::FIELD_WIDTH-1:0] common_divisor;
  logic [glu_pkg::MULT_WIDTH-1:0]  common_multiple;

  modport source (output valid, output common_divisor, output common_multiple, input ready);
  modport sink (input valid, input common_divisor, input common_multiple, output ready);
  modport monitor (input valid, input common_divisor, input common_multiple, input ready);

endinterface

// ----- src/glu_datapath.sv -----
// ----------------------------------------------------------------------------
// glu_datapath
// Operand registers, the Euclid pair, a shared restoring divider that makes
// one quotient bit per cycle, the multiplier and the result registers.
// ----------------------------------------------------------------------------
module glu_datapath #(
  parameter int VALUE_WIDTH = glu_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic [glu_pkg::FIELD_WIDTH-1:0] first_value,
  input  logic [glu_pkg::FIELD_WIDTH-1:0] second_value,
  input  glu_pkg::glu_cmd_t               cmd,
  output glu_pkg::glu_status_t            status,
  output logic [glu_pkg::FIELD_WIDTH-1:0] common_divisor,
  output logic [glu_pkg::MULT_WIDTH-1:0]  common_multiple
);

  localparam int W      = VALUE_WIDTH;
  localparam int PW     = 2 * VALUE_WIDTH;
  localparam int CW     = $clog2(VALUE_WIDTH);
  localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_WIDTH - 1);

  // Request operands, kept for the quotient and the multiply.
  logic [W-1:0]  xs;
  logic [W-1:0]  ys;
  // Euclid pair.
  logic [W-1:0]  a;
  logic [W-1:0]  b;
  // Divider state.
  logic [W-1:0]  dvs;
  logic [W-1:0]  rem;
  logic [W-1:0]  quot;
  logic [CW-1:0] cnt;
  // Product of the quotient and the second operand.
  logic [PW-1:0] prod;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic [PW-1:0] prod_next;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign shifted   = {rem, quot[W-1]};
  assign diff      = shifted - {1'b0, dvs};
  assign prod_next = PW'(quot) * PW'(ys);

  assign status.b_zero       = (b == '0);
  assign status.operand_zero = (xs == '0) || (ys == '0);
  assign status.div_last     = (cnt == LAST_BIT);

  // Operand, Euclid pair and divider registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs <= first_value[W-1:0];
      ys <= second_value[W-1:0];
      a  <= first_value[W-1:0];
      b  <= second_value[W-1:0];
    end
    if (cmd.div_start) begin
      cnt <= '0;
      rem <= '0;
      if (cmd.div_sel == glu_pkg::DIV_QUOT) begin
        dvs  <= a;
        quot <= xs;
      end else begin
        dvs  <= b;
        quot <= a;
      end
    end else if (cmd.div_step) begin
      cnt <= cnt + CW'(1);
      if (!diff[W]) begin
        rem <= diff[W-1:0];
      end else begin
        rem <= shifted[W-1:0];
      end
      quot <= {quot[W-2:0], ~diff[W]};
    end
    if (cmd.swap) begin
      a <= b;
      b <= rem;
    end
    if (cmd.mul) begin
      prod <= prod_next;
    end
  end

  // Output registers; a zero operand forces a zero multiple.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      common_divisor <= glu_pkg::FIELD_WIDTH'(a);
      if (status.operand_zero) begin
        common_multiple <= '0;
      end else begin
        common_multiple <= glu_pkg::MULT_WIDTH'(prod);
      end
    end
  end

endmodule

// ----- src/glu_ctrl.sv -----
// ----------------------------------------------------------------------------
// glu_ctrl
// Controller of the GCD/LCM unit: sequences the Euclid loop, the final
// quotient and the multiply, and runs both channel handshakes.
// ----------------------------------------------------------------------------
module glu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  glu_pkg::glu_status_t status,
  output glu_pkg::glu_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EDIV,
    S_ESWAP,
    S_QDIV,
    S_MUL,
    S_DONE
  } state_t;

  state_t state;
  logic   publish;

  assign in_ready = (state == S_IDLE);
  assign publish  = (state == S_DONE) && (!out_valid || out_ready);

  // Command decode.
  always_comb begin
    cmd           = '0;
    cmd.div_sel   = glu_pkg::DIV_EUCLID;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.div_step  = (state == S_EDIV) || (state == S_QDIV);
    cmd.swap      = (state == S_ESWAP);
    cmd.mul       = (state == S_MUL);
    cmd.publish   = publish;
    if (state == S_CHECK) begin
      if (status.b_zero) begin
        cmd.div_start = !status.operand_zero;
        cmd.div_sel   = glu_pkg::DIV_QUOT;
      end else begin
        cmd.div_start = 1'b1;
      end
    end
  end

  // State and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!status.b_zero) begin
            state <= S_EDIV;
          end else if (status.operand_zero) begin
            state <= S_DONE;
          end else begin
            state <= S_QDIV;
          end
        end
        S_EDIV: begin
          if (status.div_last) begin
            state <= S_ESWAP;
          end
        end
        S_ESWAP: begin
          state <= S_CHECK;
        end
        S_QDIV: begin
          if (status.div_last) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (publish) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/gcd_lcm_unit_core.sv -----
// ----------------------------------------------------------------------------
// gcd_lcm_unit_core
// Greatest common divisor and least common multiple of two unsigned values.
// ----------------------------------------------------------------------------
// One request at a time: the unit takes an operand pair, runs Euclid's
// remainder loop on a shared restoring divider that produces one quotient bit
// per cycle, then divides the first operand by the divisor on the same unit
// and multiplies by the second operand. A request with both operands nonzero
// runs each Euclid division and swap, then the quotient division and the
// multiply between acceptance and the next acceptance, so the divider sets
// the rate. A zero operand skips the quotient and multiply. Operand bits above
// VALUE_WIDTH are ignored. The result sits in an output register, so a new
// request is taken while an earlier result still waits to be read.
// ----------------------------------------------------------------------------
module gcd_lcm_unit_core #(
  parameter int VALUE_WIDTH = glu_pkg::VALUE_WIDTH_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  glu_in_if.sink   operands,
  glu_out_if.source results
);

  glu_pkg::glu_cmd_t    cmd;
  glu_pkg::glu_status_t status;

  // Sequencer.
  glu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic.
  glu_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .first_value     (operands.first_value),
    .second_value    (operands.second_value),
    .cmd             (cmd),
    .status          (status),
    .common_divisor  (results.common_divisor),
    .common_multiple (results.common_multiple)
  );

endmodule

// ----- src/glu_checker.sv -----
// ----------------------------------------------------------------------------
// glu_checker
// Port-level checks of the GCD/LCM unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
module glu_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            operand_valid,
  input logic                            operand_ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input logic [glu_pkg::FIELD_WIDTH-1:0] common_divisor,
  input logic [glu_pkg::MULT_WIDTH-1:0]  common_multiple
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(common_divisor) && $stable(common_multiple))
    else $error("result payload changed while stalled");

  // The unit works on one request at a time.
  assert property (@(posedge clk) disable iff (rst)
    operand_valid && operand_ready |=> !operand_ready)
    else $error("second request taken while one is in progress");

  // A zero divisor only comes from two zero operands, so the multiple is zero.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (common_divisor == '0) |-> (common_multiple == '0))
    else $error("nonzero multiple with zero divisor");

endmodule

bind gcd_lcm_unit_core glu_checker u_glu_checker (
  .clk             (clk),
  .rst             (rst),
  .operand_valid   (operands.valid),
  .operand_ready   (operands.ready),
  .result_valid    (results.valid),
  .result_ready    (results.ready),
  .common_divisor  (results.common_divisor),
  .common_multiple (results.common_multiple)
);

// ----- test/gcd_lcm_unit_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_lcm_unit_core_test
// Self-checking testbench for the GCD/LCM unit.
// ----------------------------------------------------------------------------
// A short table of operand pairs covers zeros, ones, all-ones, powers of two,
// alternating bit patterns and consecutive Fibonacci numbers, which give the
// longest Euclid loop. Random pairs follow, shaped to give shared factors,
// divisible pairs, zero operands and a spread of magnitudes. Each result is
// compared against a behavioral divisor and multiple computed in the bench.
// Both channels stall in random bursts, with calm stretches and a calm tail.
// ----------------------------------------------------------------------------
module gcd_lcm_unit_core_test;

  localparam int FIELD_WIDTH     = glu_pkg::FIELD_WIDTH;
  localparam int MULT_WIDTH      = glu_pkg::MULT_WIDTH;
  localparam int VALUE_WIDTH     = glu_pkg::VALUE_WIDTH_DEFAULT;
  localparam int NUM_DIRECTED    = 19;
  localparam int NUM_RANDOM      = 1800;
  localparam int CALM_TAIL       = 200;
  localparam int DRAIN_CYCLES    = 2000;
  localparam int CYCLE_LIMIT     = 12_000_000;

  localparam logic [FIELD_WIDTH-1:0] ALL_ONES = '1;
  localparam logic [FIELD_WIDTH-1:0] TOP_BIT  = 32'h8000_0000;
  localparam logic [FIELD_WIDTH-1:0] FIB_47   = 32'd2971215073;
  localparam logic [FIELD_WIDTH-1:0] FIB_46   = 32'd1836311903;

  // One expected result: divisor and multiple.
  typedef struct packed {
    logic [FIELD_WIDTH-1:0] divisor;
    logic [MULT_WIDTH-1:0]  multiple;
  } gcd_lcm_t;

  // One row of the directed table. Rows with known_result set carry the
  // answer; the others are checked against the computed prediction.
  typedef struct {
    logic [FIELD_WIDTH-1:0] first_op;
    logic [FIELD_WIDTH-1:0] second_op;
    bit                     known_result;
    logic [FIELD_WIDTH-1:0] divisor;
    logic [MULT_WIDTH-1:0]  multiple;
  } directed_row_t;

  logic clk;
  logic rst;

  glu_in_if  operands ();
  glu_out_if results ();

  gcd_lcm_unit_core #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .operands(operands),
    .results (results)
  );

  gcd_lcm_t    pending_results [$];
  bit          idle_enabled;
  int unsigned requests_sent;
  int unsigned zero_operand_requests;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned ready_hold;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'd0,          32'd0,          1'b1, 32'd0,          64'd0},
    '{32'd0,          32'd9,          1'b1, 32'd9,          64'd0},
    '{32'd9,          32'd0,          1'b1, 32'd9,          64'd0},
    '{32'd0,          ALL_ONES,       1'b1, ALL_ONES,       64'd0},
    '{ALL_ONES,       32'd0,          1'b1, ALL_ONES,       64'd0},
    '{32'd1,          32'd1,          1'b1, 32'd1,          64'd1},
    '{ALL_ONES,       ALL_ONES,       1'b1, ALL_ONES,       64'h0000_0000_FFFF_FFFF},
    '{32'd1,          ALL_ONES,       1'b1, 32'd1,          64'h0000_0000_FFFF_FFFF},
    '{ALL_ONES,       32'd1,          1'b1, 32'd1,          64'h0000_0000_FFFF_FFFF},
    '{32'd12,         32'd18,         1'b1, 32'd6,          64'd36},
    '{TOP_BIT,        32'd2,          1'b1, 32'd2,          64'h0000_0000_8000_0000},
    '{TOP_BIT,        32'h4000_0000,  1'b1, 32'h4000_0000,  64'h0000_0000_8000_0000},
    '{32'hAAAA_AAAA,  32'h5555_5555,  1'b1, 32'h5555_5555,  64'h0000_0000_AAAA_AAAA},
    '{ALL_ONES,       32'hFFFF_FFFE,  1'b0, 32'd0,          64'd0},
    '{FIB_47,         FIB_46,         1'b0, 32'd0,          64'd0},
    '{FIB_46,         FIB_47,         1'b0, 32'd0,          64'd0},
    '{32'h7FFF_FFFF,  ALL_ONES,       1'b0, 32'd0,          64'd0},
    '{32'hFFFF_0000,  32'h0000_FFFF,  1'b0, 32'd0,          64'd0},
    '{32'h1234_5678,  32'h9ABC_DEF0,  1'b0, 32'd0,          64'd0}
  };

  // Euclid's remainder loop on the masked operands, then (first/gcd)*second.
  function automatic gcd_lcm_t predict_gcd_lcm(input logic [FIELD_WIDTH-1:0] first_op,
                                               input logic [FIELD_WIDTH-1:0] second_op);
    logic [MULT_WIDTH-1:0] operand_mask;
    logic [MULT_WIDTH-1:0] first_m;
    logic [MULT_WIDTH-1:0] second_m;
    logic [MULT_WIDTH-1:0] x;
    logic [MULT_WIDTH-1:0] y;
    logic [MULT_WIDTH-1:0] remainder;
    gcd_lcm_t              answer;
    operand_mask = (64'd1 << VALUE_WIDTH) - 64'd1;
    first_m      = {32'd0, first_op} & operand_mask;
    second_m     = {32'd0, second_op} & operand_mask;
    x            = first_m;
    y            = second_m;
    while (y != 0) begin
      remainder = x % y;
      x         = y;
      y         = remainder;
    end
    answer.divisor  = x[FIELD_WIDTH-1:0];
    answer.multiple = '0;
    if (first_m != 0 && second_m != 0) begin
      answer.multiple = (first_m / x) * second_m;
    end
    return answer;
  endfunction

  // Random value with a random number of significant bits.
  function automatic logic [FIELD_WIDTH-1:0] random_magnitude();
    int unsigned bits;
    bits = $urandom_range(1, FIELD_WIDTH);
    return $urandom >> (FIELD_WIDTH - bits);
  endfunction

  // One of the boundary values: zero, one, all ones, a power of two, near max.
  function automatic logic [FIELD_WIDTH-1:0] boundary_value();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 32'd1;
      2:       return ALL_ONES;
      3:       return 32'd1 << $urandom_range(0, FIELD_WIDTH - 1);
      default: return ALL_ONES - $urandom_range(1, 16);
    endcase
  endfunction

  // Offer one request, optionally after an idle burst, and record its result.
  task automatic send_request(input logic [FIELD_WIDTH-1:0] first_op,
                              input logic [FIELD_WIDTH-1:0] second_op,
                              input gcd_lcm_t               expected);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      operands.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    operands.valid        <= 1'b1;
    operands.first_value  <= first_op;
    operands.second_value <= second_op;
    @(posedge clk);
    while (!operands.ready) @(posedge clk);
    pending_results.push_back(expected);
    requests_sent++;
    if (first_op == 0 || second_op == 0) begin
      zero_operand_requests++;
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter that ends a run which stops making progress.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("FAIL gcd_lcm_unit_core");
      $finish;
    end
  end

  // Result side: compare each accepted result and stall ready in bursts.
  always @(posedge clk) begin
    gcd_lcm_t want;
    if (rst) begin
      results.ready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (pending_results.size() == 0) begin
          $error("Result with no request outstanding: divisor %0d, multiple %0d",
                 results.common_divisor, results.common_multiple);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (results.common_divisor !== want.divisor) begin
            $error("common_divisor mismatch: expected %0d, actual %0d",
                   want.divisor, results.common_divisor);
            mismatch_count++;
          end
          if (results.common_multiple !== want.multiple) begin
            $error("common_multiple mismatch: expected %0d, actual %0d",
                   want.multiple, results.common_multiple);
            mismatch_count++;
          end
        end
      end
      if (ready_hold > 0) begin
        ready_hold--;
        results.ready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 15) == 0) begin
        ready_hold = $urandom_range(0, 11);
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  // Request side: reset, directed table, random pairs, then drain.
  initial begin
    logic [FIELD_WIDTH-1:0] first_op;
    logic [FIELD_WIDTH-1:0] second_op;
    logic [FIELD_WIDTH-1:0] factor;
    logic [FIELD_WIDTH-1:0] swap_tmp;
    gcd_lcm_t               expected;

    rst                   <= 1'b1;
    operands.valid        <= 1'b0;
    operands.first_value  <= '0;
    operands.second_value <= '0;
    idle_enabled          = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, with light idling on both sides.
    idle_enabled = 1'b1;
    for (int row = 0; row < NUM_DIRECTED; row++) begin
      if (directed_rows[row].known_result) begin
        expected.divisor  = directed_rows[row].divisor;
        expected.multiple = directed_rows[row].multiple;
      end else begin
        expected = predict_gcd_lcm(directed_rows[row].first_op, directed_rows[row].second_op);
      end
      send_request(directed_rows[row].first_op, directed_rows[row].second_op, expected);
    end

    // Random pairs; idling is chosen per block of 100 and is off at the tail.
    for (int item = 0; item < NUM_RANDOM; item++) begin
      if (item % 100 == 0) begin
        idle_enabled = (item < NUM_RANDOM - CALM_TAIL) && ($urandom_range(0, 2) != 0);
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          first_op  = $urandom;
          second_op = $urandom;
        end
        2, 3, 4: begin
          first_op  = random_magnitude();
          second_op = random_magnitude();
        end
        5, 6: begin
          // Shared factor, so the divisor is usually well above one.
          factor    = $urandom_range(1, 65535);
          first_op  = factor * $urandom_range(1, ALL_ONES / factor);
          second_op = factor * $urandom_range(1, ALL_ONES / factor);
        end
        7: begin
          first_op  = random_magnitude();
          second_op = '0;
          if ($urandom_range(0, 1) == 1) begin
            first_op  = '0;
            second_op = $urandom;
          end
        end
        8: begin
          // One operand divides the other.
          first_op  = $urandom_range(1, 65535);
          second_op = first_op * $urandom_range(1, ALL_ONES / first_op);
          if ($urandom_range(0, 1) == 1) begin
            swap_tmp  = first_op;
            first_op  = second_op;
            second_op = swap_tmp;
          end
        end
        default: begin
          first_op  = boundary_value();
          second_op = boundary_value();
        end
      endcase
      send_request(first_op, second_op, predict_gcd_lcm(first_op, second_op));
    end
    operands.valid <= 1'b0;

    // Wait for every outstanding result, then watch for stray ones.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operand pairs (%0d from the directed table), %0d with a zero operand.",
             requests_sent, NUM_DIRECTED, zero_operand_requests);
    $display("Checked %0d divisor/multiple results in %0d cycles under random stalls.",
             results_checked, cycle_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS gcd_lcm_unit_core");
    end else begin
      $display("FAIL gcd_lcm_unit_core");
    end
    $finish;
  end

endmodule

// ----- gcd_lcm_unit_core.f -----
src/glu_pkg.sv
src/glu_in_if.sv
src/glu_out_if.sv
src/glu_datapath.sv
src/glu_ctrl.sv
src/gcd_lcm_unit_core.sv
src/glu_checker.sv
test/gcd_lcm_unit_core_test.sv
